// ----- rtl/core/dsfd_pkg.sv -----
// dsfd_pkg: constants, result type and header byte test for the serial frame deframer.
// No dependencies; used by dsfd_frame_core and display_serial_frame_deframer_unit.
package dsfd_pkg;

    localparam int unsigned WINDOW_DEPTH = 3;
    localparam int unsigned SEQ_LEN      = WINDOW_DEPTH + 1;
    localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SEQ_W        = $clog2(SEQ_LEN + 1);
    localparam int unsigned POS_W        = $clog2(SEQ_LEN);

    localparam logic [7:0] HEAD_FIRST  = 8'h5A;
    localparam logic [7:0] HEAD_SECOND = 8'hA5;
    localparam logic [7:0] OPC_WRITE   = 8'h82;
    localparam logic [7:0] OPC_READ    = 8'h83;

    localparam logic [POS_W-1:0] POS_HEAD_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEAD_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LENGTH      = POS_W'(2);

    typedef struct packed {
        logic       emit;
        logic [7:0] content_byte;
        logic       is_first;
        logic       is_last;
        logic [7:0] frame_length;
    } res_t;

    function automatic logic byte_fits(input logic [POS_W-1:0] pos, input logic [7:0] b);
        logic fit;
        case (pos)
            POS_HEAD_FIRST:  fit = (b == HEAD_FIRST);
            POS_HEAD_SECOND: fit = (b == HEAD_SECOND);
            POS_LENGTH:      fit = (b != 8'h00);
            default:         fit = (b == OPC_WRITE) || (b == OPC_READ);
        endcase
        return fit;
    endfunction

endpackage

// ----- rtl/core/dsfd_frame_core.sv -----
// dsfd_frame_core: hunt window, frame counters and the per-byte header decision.
// Depends on dsfd_pkg. Result is combinational from held state and the staged byte.
module dsfd_frame_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    output dsfd_pkg::res_t  res
);

    logic [7:0]                   win_reg [dsfd_pkg::WINDOW_DEPTH];
    logic [7:0]                   win_next [dsfd_pkg::WINDOW_DEPTH];
    logic [dsfd_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic                         inside_reg, inside_next;
    logic [7:0]                   remaining_reg, remaining_next;
    logic [7:0]                   length_reg, length_next;

    logic [7:0]                   seq [dsfd_pkg::SEQ_LEN];
    logic [dsfd_pkg::SEQ_LEN-1:0] ok;
    logic [dsfd_pkg::SEQ_W-1:0]   n;
    logic [dsfd_pkg::SEQ_W-1:0]   start;
    logic [dsfd_pkg::SEQ_W-1:0]   m;
    logic                         hit;
    logic                         last_in;
    logic                         last_hdr;

    always_comb
    begin
        n = dsfd_pkg::SEQ_W'(fill_reg) + dsfd_pkg::SEQ_W'(1);
        for (int i = 0; i < int'(dsfd_pkg::SEQ_LEN); i++)
        begin
            if (i < int'(fill_reg))
                seq[i] = win_reg[i];
            else if (i == int'(fill_reg))
                seq[i] = rx_byte;
            else
                seq[i] = 8'h00;
        end
        // candidate start s is good if every byte from s onward fits its header slot
        for (int s = 0; s < int'(dsfd_pkg::SEQ_LEN); s++)
        begin
            ok[s] = (s < int'(n));
            for (int i = 0; i < int'(dsfd_pkg::SEQ_LEN); i++)
            begin
                if (i >= s && i < int'(n) &&
                    !dsfd_pkg::byte_fits(dsfd_pkg::POS_W'(i - s), seq[i]))
                    ok[s] = 1'b0;
            end
        end
        start = n;
        for (int s = int'(dsfd_pkg::SEQ_LEN) - 1; s >= 0; s--)
        begin
            if (ok[s])
                start = dsfd_pkg::SEQ_W'(s);
        end
        m        = n - start;
        hit      = !inside_reg && (m == dsfd_pkg::SEQ_W'(dsfd_pkg::SEQ_LEN));
        last_in  = (remaining_reg <= 8'd1);
        last_hdr = (seq[2] == 8'd1);

        fill_next      = fill_reg;
        inside_next    = inside_reg;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        for (int k = 0; k < int'(dsfd_pkg::WINDOW_DEPTH); k++)
            win_next[k] = win_reg[k];
        res = '0;

        if (inside_reg)
        begin
            res.emit         = 1'b1;
            res.content_byte = rx_byte;
            res.is_last      = last_in;
            res.frame_length = length_reg;
            if (last_in)
            begin
                remaining_next = 8'd0;
                inside_next    = 1'b0;
            end
            else
            begin
                remaining_next = remaining_reg - 8'd1;
            end
        end
        else if (hit)
        begin
            res.emit         = 1'b1;
            res.content_byte = seq[3];
            res.is_first     = 1'b1;
            res.is_last      = last_hdr;
            res.frame_length = seq[2];
            fill_next        = '0;
            for (int k = 0; k < int'(dsfd_pkg::WINDOW_DEPTH); k++)
                win_next[k] = 8'h00;
            inside_next    = !last_hdr;
            remaining_next = last_hdr ? 8'd0 : seq[2] - 8'd1;
            length_next    = seq[2];
        end
        else
        begin
            for (int k = 0; k < int'(dsfd_pkg::WINDOW_DEPTH); k++)
            begin
                if (k < int'(m))
                    win_next[k] = seq[dsfd_pkg::POS_W'(start + dsfd_pkg::SEQ_W'(k))];
                else
                    win_next[k] = 8'h00;
            end
            fill_next = dsfd_pkg::FILL_W'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < int'(dsfd_pkg::WINDOW_DEPTH); k++)
                win_reg[k] <= 8'h00;
            fill_reg      <= '0;
            inside_reg    <= 1'b0;
            remaining_reg <= 8'd0;
            length_reg    <= 8'd0;
        end
        else if (step)
        begin
            for (int k = 0; k < int'(dsfd_pkg::WINDOW_DEPTH); k++)
                win_reg[k] <= win_next[k];
            fill_reg      <= fill_next;
            inside_reg    <= inside_next;
            remaining_reg <= remaining_next;
            length_reg    <= length_next;
        end
    end

endmodule

// ----- rtl/core/display_serial_frame_deframer_unit.sv -----
// An accepted byte is held in the input stage register; its content beat is then registered at the output.
// Throughput: one byte per cycle; the input stage moves on whenever its byte yields no
// beat or the output register is free or being emptied.
// Reset (rst_n, async, low): hunt window empty, no frame in progress, both stages empty.
// Depends on dsfd_pkg and dsfd_frame_core.
module display_serial_frame_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] content_byte,
    output logic       is_first,
    output logic       is_last,
    output logic [7:0] frame_length
);

    logic           s1_valid_reg;
    logic [7:0]     s1_byte_reg;
    logic           out_valid_reg;
    logic [7:0]     content_reg;
    logic           first_reg;
    logic           last_reg;
    logic [7:0]     length_reg;
    logic           advance;
    dsfd_pkg::res_t res;

    dsfd_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (s1_byte_reg),
        .res     (res)
    );

    assign advance  = s1_valid_reg && (!res.emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance && res.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
        if (advance && res.emit)
        begin
            content_reg <= res.content_byte;
            first_reg   <= res.is_first;
            last_reg    <= res.is_last;
            length_reg  <= res.frame_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign content_byte = content_reg;
    assign is_first     = first_reg;
    assign is_last      = last_reg;
    assign frame_length = length_reg;

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_reg |-> length_reg != 8'd0)
        else $error("command beat with zero length");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_reg && length_reg == 8'd1 |-> last_reg)
        else $error("single byte frame not marked last");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("staged byte lost while stalled");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.emit |-> !out_valid_reg || out_ready)
        else $error("output beat overwritten");

endmodule
